[rtl/core/dgmb_pkg.sv]
// shared constants for the depth grid mesh builder
// register indexes, reset values and record widths; no dependencies
package dgmb_pkg;

   localparam int MAX_COLUMNS_DEF = 128;
   localparam int DEPTH_BITS_DEF  = 13;

   localparam int MAX_ROWS   = 128;
   localparam int VNUM_W     = 14;
   localparam int COORD_W    = 12;
   localparam int COORD_MAX  = 4095;
   localparam int CSR_IDX_W  = 3;

   localparam int NEAR_RESET    = 50;
   localparam int FAR_RESET     = 1000;
   localparam int COLUMNS_RESET = 103;
   localparam int ROWS_RESET    = 85;
   localparam int SPACING_RESET = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NEAR_LIMIT     = 3'd0,
      REG_FAR_LIMIT      = 3'd1,
      REG_GRID_COLUMNS   = 3'd2,
      REG_GRID_ROWS      = 3'd3,
      REG_SAMPLE_SPACING = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      SLOT_VERTEX = 2'd0,
      SLOT_TRI_A  = 2'd1,
      SLOT_TRI_B  = 2'd2
   } slot_type;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

endpackage

[rtl/core/depth_grid_mesh_builder_unit.sv]
// depth grid mesh builder top level: vertex numbering, row buffer and result queue
// depends on dgmb_pkg
//
// Depth samples arrive in raster order, one per transfer. A sample with
// near_limit < distance < far_limit becomes a vertex record; when its 2x2 quad
// (sample as bottom-right corner) has four valid corners, two triangle records
// follow the vertex. The result port moves one record per cycle while rsp_ready
// is high. A rejected sample gives no record, a vertex-only one gives one and a
// quad-closing one three; a new sample is taken in the cycle the last record of
// the previous one is transferred. The row buffer is a one-write one-read memory
// of MAX_COLUMNS vertex numbers whose read for the next column is issued ahead,
// with per-column valid bits in flops; there is no clearing pass after reset.
module depth_grid_mesh_builder_unit #(
   parameter int MAX_COLUMNS = dgmb_pkg::MAX_COLUMNS_DEF,
   parameter int DEPTH_BITS  = dgmb_pkg::DEPTH_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [DEPTH_BITS-1:0]              req_distance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic [dgmb_pkg::COORD_W-1:0]       rsp_pos_x,
   output logic [dgmb_pkg::COORD_W-1:0]       rsp_pos_y,
   output logic signed [DEPTH_BITS+1:0]       rsp_pos_z,
   output logic [dgmb_pkg::VNUM_W-1:0]        rsp_corner_a,
   output logic [dgmb_pkg::VNUM_W-1:0]        rsp_corner_b,
   output logic [dgmb_pkg::VNUM_W-1:0]        rsp_corner_c,
   output logic                               rsp_last,
   input  logic                               csr_wen,
   input  logic [dgmb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [DEPTH_BITS-1:0]              csr_wdata
);

   localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CMP_W = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int XW    = (CW + 6 > 13) ? CW + 6 : 13;
   localparam int YW    = 13;
   localparam int RW    = $clog2(dgmb_pkg::MAX_ROWS);
   localparam int VW    = dgmb_pkg::VNUM_W;
   localparam int ZW    = DEPTH_BITS + 2;

   // configuration
   logic [DEPTH_BITS-1:0] near_ff, far_ff;
   logic [7:0]            cols_ff, rows_ff;
   logic [5:0]            spacing_ff;

   // frame walk state
   logic [CW-1:0]          col_ff, col_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [VW-1:0]          vcnt_ff, vcnt_in;
   logic [VW-1:0]          left_num_ff, left_num_in;
   logic                   left_v_ff, left_v_in;
   logic [VW-1:0]          held_ff;
   logic                   held_v_ff, held_v_in;
   logic [MAX_COLUMNS-1:0] rowv_ff;

   // row buffer
   logic [VW-1:0] row_mem [MAX_COLUMNS];
   logic [VW-1:0] rd_ff;

   // result queue
   logic                  busy_ff, busy_in;
   dgmb_pkg::slot_type    slot_ff, slot_in;
   logic                  tri_ff;
   logic [dgmb_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [ZW-1:0]         z_ff;
   logic [VW-1:0]         tl_ff, tr_ff, br_ff, bl_ff;

   logic              accept, out_xfer, out_last;
   logic              samp_ok, quad, end_row, end_frame;
   logic [CMP_W-1:0]  cols_raw, cols_eff;
   logic [8:0]        rows_raw, rows_eff;
   logic [XW-1:0]     x_prod;
   logic [YW-1:0]     y_prod;
   logic [dgmb_pkg::COORD_W-1:0] x_sat, y_sat;
   logic [ZW-1:0]     z_val;
   logic [CW-1:0]     rd_addr;
   logic              old_trv;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff    <= DEPTH_BITS'(dgmb_pkg::NEAR_RESET);
         far_ff     <= DEPTH_BITS'(dgmb_pkg::FAR_RESET);
         cols_ff    <= 8'(dgmb_pkg::COLUMNS_RESET);
         rows_ff    <= 8'(dgmb_pkg::ROWS_RESET);
         spacing_ff <= 6'(dgmb_pkg::SPACING_RESET);
      end else if (csr_wen) begin
         case (csr_index)
            dgmb_pkg::REG_NEAR_LIMIT:     near_ff    <= csr_wdata;
            dgmb_pkg::REG_FAR_LIMIT:      far_ff     <= csr_wdata;
            dgmb_pkg::REG_GRID_COLUMNS:   cols_ff    <= csr_wdata[7:0];
            dgmb_pkg::REG_GRID_ROWS:      rows_ff    <= csr_wdata[7:0];
            dgmb_pkg::REG_SAMPLE_SPACING: spacing_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign out_last = (slot_ff == dgmb_pkg::SLOT_TRI_B) ||
                     ((slot_ff == dgmb_pkg::SLOT_VERTEX) && !tri_ff);
   assign out_xfer = busy_ff && rsp_ready;
   assign req_ready = !busy_ff || (rsp_ready && out_last);
   assign accept    = req_valid && req_ready;

   // sample decode
   always_comb begin
      samp_ok  = (req_distance > near_ff) && (req_distance < far_ff);
      old_trv  = rowv_ff[col_ff];
      quad     = samp_ok && (row_ff != '0) && (col_ff != '0) && left_v_ff &&
                 held_v_ff && old_trv;

      cols_raw = CMP_W'(cols_ff);
      if (cols_raw == '0) begin
         cols_eff = CMP_W'(1);
      end else if (cols_raw > CMP_W'(MAX_COLUMNS)) begin
         cols_eff = CMP_W'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_raw;
      end
      rows_raw = {1'b0, rows_ff};
      if (rows_raw == '0) begin
         rows_eff = 9'd1;
      end else if (rows_raw > 9'(dgmb_pkg::MAX_ROWS)) begin
         rows_eff = 9'(dgmb_pkg::MAX_ROWS);
      end else begin
         rows_eff = rows_raw;
      end
      end_row   = (CMP_W'(col_ff) + CMP_W'(1)) >= cols_eff;
      end_frame = (9'(row_ff) + 9'd1) >= rows_eff;

      x_prod = XW'(col_ff) * XW'(spacing_ff);
      y_prod = YW'(row_ff) * YW'(spacing_ff);
      x_sat  = (x_prod > XW'(dgmb_pkg::COORD_MAX)) ?
               dgmb_pkg::COORD_W'(dgmb_pkg::COORD_MAX) : x_prod[dgmb_pkg::COORD_W-1:0];
      y_sat  = (y_prod > YW'(dgmb_pkg::COORD_MAX)) ?
               dgmb_pkg::COORD_W'(dgmb_pkg::COORD_MAX) : y_prod[dgmb_pkg::COORD_W-1:0];
      z_val  = ZW'(0) - {1'b0, req_distance, 1'b0};
   end

   // next frame walk state
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      vcnt_in     = vcnt_ff;
      left_num_in = left_num_ff;
      left_v_in   = left_v_ff;
      held_v_in   = held_v_ff;
      if (accept) begin
         held_v_in = old_trv;
         if (samp_ok) begin
            left_num_in = vcnt_ff;
            left_v_in   = 1'b1;
            vcnt_in     = vcnt_ff + VW'(1);
         end else begin
            left_v_in = 1'b0;
         end
         if (end_row) begin
            col_in    = '0;
            left_v_in = 1'b0;
            held_v_in = 1'b0;
            if (end_frame) begin
               row_in  = '0;
               vcnt_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         vcnt_ff     <= '0;
         left_num_ff <= '0;
         left_v_ff   <= 1'b0;
         held_v_ff   <= 1'b0;
         held_ff     <= '0;
         rowv_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         vcnt_ff     <= vcnt_in;
         left_num_ff <= left_num_in;
         left_v_ff   <= left_v_in;
         held_v_ff   <= held_v_in;
         if (accept) begin
            held_ff         <= rd_ff;
            rowv_ff[col_ff] <= samp_ok;
         end
      end
   end

   // row buffer, read for the column of the next sample
   assign rd_addr = col_in;

   always_ff @(posedge clock) begin
      if (accept && samp_ok) begin
         row_mem[col_ff] <= vcnt_ff;
      end
      if (accept && samp_ok && (rd_addr == col_ff)) begin
         rd_ff <= vcnt_ff;
      end else begin
         rd_ff <= row_mem[rd_addr];
      end
   end

   // result queue control
   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (out_xfer) begin
         if (out_last) begin
            busy_in = 1'b0;
         end else if (slot_ff == dgmb_pkg::SLOT_VERTEX) begin
            slot_in = dgmb_pkg::SLOT_TRI_A;
         end else begin
            slot_in = dgmb_pkg::SLOT_TRI_B;
         end
      end
      if (accept && samp_ok) begin
         busy_in = 1'b1;
         slot_in = dgmb_pkg::SLOT_VERTEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= dgmb_pkg::SLOT_VERTEX;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      if (accept && samp_ok) begin
         tri_ff <= quad;
         x_ff   <= x_sat;
         y_ff   <= y_sat;
         z_ff   <= z_val;
         tl_ff  <= held_ff;
         tr_ff  <= rd_ff;
         br_ff  <= vcnt_ff;
         bl_ff  <= left_num_ff;
      end
   end

   // output select
   always_comb begin
      rsp_valid    = busy_ff;
      rsp_last     = out_last;
      rsp_kind     = dgmb_pkg::KIND_TRIANGLE;
      rsp_pos_x    = '0;
      rsp_pos_y    = '0;
      rsp_pos_z    = '0;
      rsp_corner_a = tl_ff;
      rsp_corner_b = tr_ff;
      rsp_corner_c = br_ff;
      case (slot_ff)
         dgmb_pkg::SLOT_VERTEX: begin
            rsp_kind     = dgmb_pkg::KIND_VERTEX;
            rsp_pos_x    = x_ff;
            rsp_pos_y    = y_ff;
            rsp_pos_z    = $signed(z_ff);
            rsp_corner_a = '0;
            rsp_corner_b = '0;
            rsp_corner_c = '0;
         end
         dgmb_pkg::SLOT_TRI_A: begin
            rsp_corner_b = tr_ff;
            rsp_corner_c = br_ff;
         end
         dgmb_pkg::SLOT_TRI_B: begin
            rsp_corner_b = br_ff;
            rsp_corner_c = bl_ff;
         end
         default: ;
      endcase
   end

endmodule
